### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define DCF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define DCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dcf_pkg.sv
// Shared types and constants for the drive command frame decoder
`timescale 1ns / 1ps

package dcf_pkg;

  localparam logic [1:0] RegHeaderFirst  = 2'd0;
  localparam logic [1:0] RegHeaderSecond = 2'd1;
  localparam logic [1:0] RegLinearGain   = 2'd2;
  localparam logic [1:0] RegAngularGain  = 2'd3;

  localparam logic [7:0]  HeaderFirstRst  = 8'hAA;
  localparam logic [7:0]  HeaderSecondRst = 8'h55;
  localparam logic [15:0] LinearGainRst   = 16'd12902;
  localparam logic [15:0] AngularGainRst  = 16'd4567;

  // Classified frame word handed from the parser to the executor
  typedef struct packed {
    logic        ok;
    logic [31:0] lin_bits;
    logic [31:0] turn_bits;
  } frame_t;

  typedef struct packed {
    logic   push;
    frame_t frame;
  } push_t;

endpackage

### hw/rtl/dcf_front.sv
// Header hunt, payload collection and checksum check
`timescale 1ns / 1ps

module dcf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic [7:0]     header_first_i,
  input  logic [7:0]     header_second_i,
  input  logic           q_full_i,
  output dcf_pkg::push_t push_o
);

  localparam logic [3:0] PosHunt   = 4'd0;
  localparam logic [3:0] PosSecond = 4'd1;
  localparam logic [3:0] PosFirstP = 4'd2;
  localparam logic [3:0] PosLastP  = 4'd10;

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [63:0] payload_q, payload_d;
  logic        take;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    payload_d = payload_q;
    push_o.push           = 1'b0;
    push_o.frame.ok       = (sum_q == rx_byte_i);
    push_o.frame.lin_bits  = payload_q[31:0];
    push_o.frame.turn_bits = payload_q[63:32];
    if (take) begin
      if (pos_q == PosSecond) begin
        pos_d = (rx_byte_i == header_second_i) ? PosFirstP : PosHunt;
        sum_d = 8'd0;
      end else if (pos_q < PosFirstP || pos_q > PosLastP) begin
        pos_d = (rx_byte_i == header_first_i) ? PosSecond : PosHunt;
      end else if (pos_q != PosLastP) begin
        sum_d     = sum_q + rx_byte_i;
        payload_d = {rx_byte_i, payload_q[63:8]};
        pos_d     = pos_q + 4'd1;
      end else begin
        push_o.push = 1'b1;
        pos_d       = PosHunt;
        sum_d       = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
      sum_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

endmodule

### hw/rtl/dcf_queue.sv
// Two-entry queue of frame words between parser and executor
`timescale 1ns / 1ps

module dcf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dcf_pkg::push_t  push_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output dcf_pkg::frame_t frame_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  dcf_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign frame_o = mem_q[rd_q];
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.frame;
  end

endmodule

### hw/rtl/dcf_back.sv
// Float conversion, gain multiply, mix, clamp and held commands
`timescale 1ns / 1ps

module dcf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  dcf_pkg::frame_t q_frame_i,
  output logic            q_pop_o,
  input  logic [15:0]     linear_gain_i,
  input  logic [15:0]     angular_gain_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            frame_ok_o,
  output logic [7:0]      left_cmd_o,
  output logic [7:0]      right_cmd_o
);

  localparam logic [7:0] ExpInf  = 8'd255;
  localparam logic [7:0] ExpSat  = 8'd142;
  localparam logic [7:0] ExpUnit = 8'd134;
  localparam logic [7:0] ExpLow  = 8'd110;
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic signed [49:0] ClampPos = 50'sd1677721600;
  localparam logic signed [49:0] ClampNeg = -50'sd1677721600;

  function automatic logic signed [31:0] f2q(input logic [31:0] bits);
    logic        neg;
    logic [7:0]  ex;
    logic [31:0] man;
    logic [31:0] mag;
    logic [4:0]  sh;
    neg = bits[31];
    ex  = bits[30:23];
    man = {8'd0, 1'b1, bits[22:0]};
    mag = '0;
    sh  = '0;
    if (ex == ExpInf) begin
      if (bits[22:0] != '0) f2q = '0;
      else f2q = neg ? QMin : QMax;
    end else if (ex == 8'd0) begin
      f2q = '0;
    end else if (ex >= ExpSat) begin
      f2q = neg ? QMin : QMax;
    end else begin
      if (ex >= ExpUnit) begin
        sh  = 5'(ex - ExpUnit);
        mag = man << sh;
      end else if (ex > ExpLow) begin
        sh  = 5'(ExpUnit - ex);
        mag = man >> sh;
      end
      f2q = neg ? -$signed(mag) : $signed(mag);
    end
  endfunction

  logic adv;

  logic                s1_valid_q, s1_ok_q;
  logic signed [31:0]  s1_lin_q, s1_turn_q;
  logic                s2_valid_q, s2_ok_q;
  logic signed [48:0]  s2_lterm_q, s2_aterm_q;
  logic                s3_valid_q, s3_ok_q;
  logic signed [49:0]  s3_left_q, s3_right_q;

  logic                out_valid_q, frame_ok_q;
  logic [7:0]          left_q, right_q, held_l_q, held_r_q;
  logic [7:0]          left_d, right_d;

  function automatic logic [7:0] to_pct(input logic signed [49:0] v);
    logic signed [49:0] c;
    logic [31:0]        m;
    logic [7:0]         p;
    if (v > ClampPos)      c = ClampPos;
    else if (v < ClampNeg) c = ClampNeg;
    else                   c = v;
    m = c[49] ? 32'(-c) : c[31:0];
    p = m[31:24];
    to_pct = c[49] ? -p : p;
  endfunction

  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  assign left_d  = s3_ok_q ? to_pct(s3_left_q)  : held_l_q;
  assign right_d = s3_ok_q ? to_pct(s3_right_q) : held_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_l_q    <= 8'd0;
      held_r_q    <= 8'd0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        held_l_q <= left_d;
        held_r_q <= right_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ok_q    <= q_frame_i.ok;
      s1_lin_q   <= f2q(q_frame_i.lin_bits);
      s1_turn_q  <= f2q(q_frame_i.turn_bits);
      s2_ok_q    <= s1_ok_q;
      s2_lterm_q <= s1_lin_q * $signed({1'b0, linear_gain_i});
      s2_aterm_q <= s1_turn_q * $signed({1'b0, angular_gain_i});
      s3_ok_q    <= s2_ok_q;
      s3_left_q  <= 50'(s2_lterm_q) - 50'(s2_aterm_q);
      s3_right_q <= 50'(s2_lterm_q) + 50'(s2_aterm_q);
      frame_ok_q <= s3_ok_q;
      left_q     <= left_d;
      right_q    <= right_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_ok_o  = frame_ok_q;
  assign left_cmd_o  = left_q;
  assign right_cmd_o = right_q;

endmodule

### hw/rtl/drive_command_frame_to_wheel_percent.sv
// Top level of the drive command frame decoder
//
//   word     | direction | contents
//   rx byte  | in        | rx_byte_i
//   result   | out       | frame_ok_o, left_cmd_o, right_cmd_o
//   config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// One byte is taken every cycle unless the queue is full; the parser holds frame
// position, checksum and payload. After the checksum byte a result passes the queue
// and the back end (convert, multiply, mix, clamp), one frame per cycle unless the output stalls.
// A two-frame queue parts parser and back end; bytes stall only when it is full.
// Reset returns the parser to hunting, clears held commands, loads default registers.
`timescale 1ns / 1ps

module drive_command_frame_to_wheel_percent (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic [7:0]  left_cmd_o,
  output logic [7:0]  right_cmd_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  hdr_first_q, hdr_second_q;
  logic [15:0] lin_gain_q, ang_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= dcf_pkg::HeaderFirstRst;
      hdr_second_q <= dcf_pkg::HeaderSecondRst;
      lin_gain_q   <= dcf_pkg::LinearGainRst;
      ang_gain_q   <= dcf_pkg::AngularGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dcf_pkg::RegHeaderFirst:  hdr_first_q  <= cfg_data_i[7:0];
        dcf_pkg::RegHeaderSecond: hdr_second_q <= cfg_data_i[7:0];
        dcf_pkg::RegLinearGain:   lin_gain_q   <= cfg_data_i;
        dcf_pkg::RegAngularGain:  ang_gain_q   <= cfg_data_i;
        default:                  lin_gain_q   <= lin_gain_q;
      endcase
    end
  end

  dcf_pkg::push_t  push;
  dcf_pkg::frame_t q_frame;
  logic            q_full, q_valid, q_pop;

  dcf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .header_first_i  (hdr_first_q),
    .header_second_i (hdr_second_q),
    .q_full_i        (q_full),
    .push_o          (push)
  );

  dcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .frame_o (q_frame)
  );

  dcf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_frame_i      (q_frame),
    .q_pop_o        (q_pop),
    .linear_gain_i  (lin_gain_q),
    .angular_gain_i (ang_gain_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_ok_o     (frame_ok_o),
    .left_cmd_o     (left_cmd_o),
    .right_cmd_o    (right_cmd_o)
  );

endmodule

### hw/rtl/dcf_checker.sv
// Port-level checks on the result word of the frame decoder
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       frame_ok_o,
  input logic [7:0] left_cmd_o,
  input logic [7:0] right_cmd_o
);

  `DCF_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result during reset")

  `DCF_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable({frame_ok_o, left_cmd_o, right_cmd_o}), "stalled result changed")

  `DCF_ASSERT(a_left_range, clk_i, rst_ni, out_valid_o |-> ($signed(left_cmd_o) <= 8'sd100) && ($signed(left_cmd_o) >= -8'sd100), "left command out of range")

  `DCF_ASSERT(a_right_range, clk_i, rst_ni, out_valid_o |-> ($signed(right_cmd_o) <= 8'sd100) && ($signed(right_cmd_o) >= -8'sd100), "right command out of range")

endmodule

bind drive_command_frame_to_wheel_percent dcf_checker u_dcf_checker (.*);

### tb/tb.sv
// Self-checking testbench for the drive command frame decoder
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned PHASE_BYTES = 220;
  localparam int unsigned HOLD_CYCLES = 250;

  localparam int POS_HUNT = 0;
  localparam int POS_SECOND = 1;
  localparam int POS_PAYLOAD = 2;
  localparam int POS_CHECKSUM = 10;

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;
  localparam longint Q24_ONE = 64'sd16777216;
  localparam longint PCT_LIMIT = 100 * Q24_ONE;

  localparam logic [7:0] FULL_FWD = 8'h64;

  typedef struct packed {
    logic       ok;
    logic [7:0] left;
    logic [7:0] right;
  } wheel_cmd_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       known;
    wheel_cmd_t cmd;
  } script_row_t;

  localparam wheel_cmd_t NO_CMD = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        frame_ok_o;
  logic [7:0]  left_cmd_o;
  logic [7:0]  right_cmd_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  drive_command_frame_to_wheel_percent i_dut (.*);

  // predictor copy of registers and frame state
  logic [7:0]  hdr_first = dcf_pkg::HeaderFirstRst;
  logic [7:0]  hdr_second = dcf_pkg::HeaderSecondRst;
  logic [15:0] lin_gain = dcf_pkg::LinearGainRst;
  logic [15:0] ang_gain = dcf_pkg::AngularGainRst;
  int          frame_pos = POS_HUNT;
  logic [7:0]  payload [9];
  logic [7:0]  payload_sum = '0;
  logic [7:0]  held_left = '0;
  logic [7:0]  held_right = '0;

  wheel_cmd_t  expected_cmds [$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  // header noise, header pair, +inf linear with header bytes in payload,
  // then -inf linear with a bad checksum (commands held)
  script_row_t opening_script [25] = '{
    '{8'hAA, 1'b0, NO_CMD}, '{8'hAA, 1'b0, NO_CMD}, '{8'h55, 1'b0, NO_CMD},
    '{8'hAA, 1'b0, NO_CMD}, '{8'h55, 1'b0, NO_CMD},
    '{8'h00, 1'b0, NO_CMD}, '{8'h00, 1'b0, NO_CMD}, '{8'h80, 1'b0, NO_CMD},
    '{8'h7F, 1'b0, NO_CMD}, '{8'hAA, 1'b0, NO_CMD}, '{8'h55, 1'b0, NO_CMD},
    '{8'h00, 1'b0, NO_CMD}, '{8'h00, 1'b0, NO_CMD},
    '{8'hFE, 1'b1, '{1'b1, FULL_FWD, FULL_FWD}},
    '{8'hAA, 1'b0, NO_CMD}, '{8'h55, 1'b0, NO_CMD},
    '{8'h00, 1'b0, NO_CMD}, '{8'h00, 1'b0, NO_CMD}, '{8'h80, 1'b0, NO_CMD},
    '{8'hFF, 1'b0, NO_CMD}, '{8'h00, 1'b0, NO_CMD}, '{8'h00, 1'b0, NO_CMD},
    '{8'h00, 1'b0, NO_CMD}, '{8'h00, 1'b0, NO_CMD},
    '{8'h00, 1'b1, '{1'b0, FULL_FWD, FULL_FWD}}
  };

  function automatic longint q16_of_float(input logic [31:0] bits);
    int     sh;
    longint mag;
    if (bits[30:23] == 8'hFF) begin
      if (bits[22:0] != '0) return 0;
      return bits[31] ? Q16_MIN : Q16_MAX;
    end
    if (bits[30:23] == 8'h00) return 0;
    sh = int'(bits[30:23]) - 134;
    if (sh >= 8) return bits[31] ? Q16_MIN : Q16_MAX;
    mag = longint'({1'b1, bits[22:0]});
    if (sh >= 0) mag = mag <<< sh;
    else if (sh > -24) mag = mag >> (-sh);
    else mag = 0;
    if (mag > Q16_MAX) mag = Q16_MAX;
    return bits[31] ? -mag : mag;
  endfunction

  function automatic logic [7:0] percent_of_q24(input longint v);
    if (v > PCT_LIMIT) v = PCT_LIMIT;
    if (v < -PCT_LIMIT) v = -PCT_LIMIT;
    return 8'(v / Q24_ONE);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output wheel_cmd_t cmd);
    longint lin;
    longint turn;
    longint lterm;
    longint aterm;
    cmd = NO_CMD;
    if (frame_pos == POS_SECOND) begin
      frame_pos = (b == hdr_second) ? POS_PAYLOAD : POS_HUNT;
      payload_sum = '0;
      return 1'b0;
    end
    if (frame_pos < POS_PAYLOAD || frame_pos > POS_CHECKSUM) begin
      frame_pos = (b == hdr_first) ? POS_SECOND : POS_HUNT;
      return 1'b0;
    end
    payload[frame_pos - POS_PAYLOAD] = b;
    if (frame_pos != POS_CHECKSUM) begin
      payload_sum += b;
      frame_pos++;
      return 1'b0;
    end
    frame_pos = POS_HUNT;
    cmd.ok = (payload_sum == b);
    if (cmd.ok) begin
      lin = q16_of_float({payload[3], payload[2], payload[1], payload[0]});
      turn = q16_of_float({payload[7], payload[6], payload[5], payload[4]});
      lterm = lin * longint'(lin_gain);
      aterm = turn * longint'(ang_gain);
      held_left = percent_of_q24(lterm - aterm);
      held_right = percent_of_q24(lterm + aterm);
    end
    payload_sum = '0;
    cmd.left = held_left;
    cmd.right = held_right;
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [7:0] expo;
    case ($urandom_range(11))
      0: return {1'($urandom), 8'hFF, 23'h0};
      1: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      2: return {1'($urandom), 8'h00, 23'($urandom)};
      3: return {1'($urandom), 31'h0};
      4: return $urandom;
      5: expo = 8'($urandom_range(142, 254));
      6: expo = 8'($urandom_range(1, 109));
      default: expo = 8'($urandom_range(110, 141));
    endcase
    return {1'($urandom), expo, 23'($urandom)};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic known,
                           input wheel_cmd_t known_cmd);
    wheel_cmd_t cmd;
    while (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    if (decode_byte(b, cmd)) expected_cmds.push_back(known ? known_cmd : cmd);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [7:0] hf, input logic [7:0] hs,
                           input logic [15:0] lg, input logic [15:0] ag);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{dcf_pkg::RegHeaderFirst, dcf_pkg::RegHeaderSecond,
            dcf_pkg::RegLinearGain, dcf_pkg::RegAngularGain};
    val = '{{8'h00, hf}, {8'h00, hs}, lg, ag};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    hdr_first  = hf;
    hdr_second = hs;
    lin_gain   = lg;
    ang_gain   = ag;
  endtask

  task automatic flag_error(input string msg);
    if (mismatches < 10) $display("%t ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, one long hold-off, and the checker
  initial begin : result_side
    wheel_cmd_t got;
    wheel_cmd_t want;
    int unsigned backpressure_cycles;
    backpressure_cycles = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{frame_ok_o, left_cmd_o, right_cmd_o};
        if (expected_cmds.size() == 0) begin
          flag_error($sformatf("unexpected word ok=%0b left=%0d right=%0d",
                               got.ok, $signed(got.left), $signed(got.right)));
        end else begin
          want = expected_cmds.pop_front();
          if (got.ok !== want.ok)
            flag_error($sformatf("frame_ok exp %0b got %0b", want.ok, got.ok));
          if (got.left !== want.left)
            flag_error($sformatf("left_cmd exp %0d got %0d",
                                 $signed(want.left), $signed(got.left)));
          if (got.right !== want.right)
            flag_error($sformatf("right_cmd exp %0d got %0d",
                                 $signed(want.right), $signed(got.right)));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        backpressure_cycles = HOLD_CYCLES;
      end
      if (backpressure_cycles != 0) begin
        out_stall_i <= 1'b1;
        backpressure_cycles--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 8);
      end
    end
  end

  initial begin : byte_side
    logic [7:0]  burst [$];
    logic [63:0] body;
    logic [7:0]  csum;
    logic [7:0]  nb;
    int unsigned kind;
    int unsigned sent;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= dcf_pkg::RegHeaderFirst;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: load_regs(8'h00, 8'hFF, 16'hFFFF, 16'h0000);
          2: load_regs(8'hFF, 8'h00, 16'h0000, 16'hFFFF);
          3: load_regs(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
          4: load_regs(8'($urandom), 8'($urandom),
                       16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)));
          default: load_regs(dcf_pkg::HeaderFirstRst, dcf_pkg::HeaderSecondRst,
                             dcf_pkg::LinearGainRst, dcf_pkg::AngularGainRst);
        endcase
      end
      calm = (ph == 4);
      if (ph == 0) begin
        foreach (opening_script[i])
          send_byte(opening_script[i].rx, opening_script[i].known, opening_script[i].cmd);
      end
      if (ph == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        burst.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
          // header pair broken by a wrong second byte
          burst.push_back(hdr_first);
          do nb = 8'($urandom); while (nb == hdr_second);
          burst.push_back(nb);
        end else if (kind < 15) begin
          repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom));
        end else begin
          body = {rand_float(), rand_float()};
          csum = '0;
          burst.push_back(hdr_first);
          burst.push_back(hdr_second);
          for (int i = 0; i < 8; i++) begin
            burst.push_back(body[8*i +: 8]);
            csum += body[8*i +: 8];
          end
          if (kind < 27) csum ^= 8'($urandom_range(1, 255));
          else if (kind < 32) csum = 8'($urandom);
          burst.push_back(csum);
        end
        foreach (burst[i]) send_byte(burst[i], 1'b0, NO_CMD);
        sent += burst.size();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
